// ----- src/wtrm_pkg.sv -----
// ----------------------------------------------------------------------------
// wtrm_pkg: shared types and constants of the traffic rate meter
// Payload structs, register indexes, field widths and divider status.
// ----------------------------------------------------------------------------
package wtrm_pkg;

  localparam int MAX_WINDOW_DEF = 16;

  localparam int DEV_W      = 8;
  localparam int CNT_W      = 48;
  localparam int PM_W       = 16;
  localparam int WIN_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  // Divider operands: (49-bit value) * 1000 over a 49-bit divisor
  localparam int DIV_DEN_W = CNT_W + 1;
  localparam int DIV_NUM_W = DIV_DEN_W + 10;

  localparam logic [WIN_W-1:0] WIN_RESET = 5'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SAMPLES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_IN_RATE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_OUT_RATE   = 2'd2;

  typedef struct packed {
    logic [DEV_W-1:0] device_id;
    logic [CNT_W-1:0] in_bytes;
    logic [CNT_W-1:0] out_bytes;
    logic [CNT_W-1:0] time_ms;
  } sample_t;

  typedef struct packed {
    logic [CNT_W-1:0] in_total;
    logic [CNT_W-1:0] out_total;
    logic [CNT_W-1:0] in_rate;
    logic [CNT_W-1:0] out_rate;
    logic [PM_W-1:0]  in_permille;
    logic [PM_W-1:0]  out_permille;
    logic [PM_W-1:0]  total_permille;
  } result_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ----- src/windowed_traffic_rate_meter.sv -----
// ----------------------------------------------------------------------------
// windowed_traffic_rate_meter: sliding window traffic rate meter
// Holds the newest counter samples in a ring and reports totals, rates and
// permille of link capacity for every request.
// ----------------------------------------------------------------------------
// One request is taken at a time. It passes the ring steps in order (accept,
// drop of old samples, store and read of the oldest, span check), then runs
// five jobs: in rate, out rate, in, out and total permille. A job that has a
// division spends almost all of its time in the shared bit-serial divider; a
// job whose result is zero skips the divider. The result waits in an output
// register, and the next request is accepted while it waits. Configuration
// is written through a plain write port; window_samples is clamped to
// 1..MAX_WINDOW when used.
// ----------------------------------------------------------------------------
module windowed_traffic_rate_meter #(
  parameter int MAX_WINDOW = wtrm_pkg::MAX_WINDOW_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  wtrm_pkg::sample_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output wtrm_pkg::result_t                 out_data,
  input  logic                              cfg_we,
  input  logic [wtrm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wtrm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import wtrm_pkg::*;

  localparam int IDX_W  = $clog2(MAX_WINDOW);
  localparam int FILL_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = FILL_W + 1;
  localparam int CMP_W  = (FILL_W > WIN_W) ? FILL_W : WIN_W;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RING  = 9'b000000010,
    S_WRITE = 9'b000000100,
    S_CHECK = 9'b000001000,
    S_PREP  = 9'b000010000,
    S_MUL   = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_OUT   = 9'b010000000,
    S_NEXT  = 9'b100000000
  } state_t;

  typedef enum logic [2:0] {
    J_IN_RATE,
    J_OUT_RATE,
    J_IN_PM,
    J_OUT_PM,
    J_TOT_PM
  } job_t;

  // configuration
  logic [WIN_W-1:0] cfg_win;
  logic [CNT_W-1:0] max_in;
  logic [CNT_W-1:0] max_out;

  // control
  state_t           state;
  job_t             job;
  logic [IDX_W-1:0] ring_head;
  logic [FILL_W-1:0] ring_fill;

  // ring memory and sample registers
  sample_t ring_mem [MAX_WINDOW];
  sample_t smp_new;
  sample_t smp_old;

  // span of the window
  logic             span_ok;
  logic             in_fell;
  logic             out_fell;
  logic [CNT_W-1:0] delta_in;
  logic [CNT_W-1:0] delta_out;
  logic [CNT_W-1:0] dt;

  // job operands and results
  logic [DIV_DEN_W-1:0] mul_x;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 job_ok;
  logic [DIV_NUM_W-1:0] div_num;
  logic                 div_start;
  div_status_t          div_stat;
  logic [DIV_NUM_W-1:0] div_quot;
  logic                 job_go;
  logic                 job_wr;
  logic [DIV_NUM_W-1:0] job_q;

  logic [CNT_W-1:0] in_rate;
  logic [CNT_W-1:0] out_rate;
  logic [PM_W-1:0]  in_pm;
  logic [PM_W-1:0]  out_pm;
  logic [PM_W-1:0]  tot_pm;

  // window arithmetic
  logic [CMP_W-1:0]  win_ext;
  logic [CMP_W-1:0]  win_max;
  logic [CMP_W-1:0]  win_clamp;
  logic [FILL_W-1:0] win;
  logic [SUM_W-1:0]  head_sum;
  logic [SUM_W-1:0]  slot_sum;
  logic [IDX_W-1:0]  slot;

  logic [CNT_W:0] sub_in;
  logic [CNT_W:0] sub_out;

  function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] r;
    r = (s >= SUM_W'(MAX_WINDOW)) ? s - SUM_W'(MAX_WINDOW) : s;
    return r[IDX_W-1:0];
  endfunction

  // 1000 = 1024 - 16 - 8
  function automatic logic [DIV_NUM_W-1:0] times_1000(input logic [DIV_DEN_W-1:0] x);
    return {x, 10'b0} - {6'b0, x, 4'b0} - {7'b0, x, 3'b0};
  endfunction

  function automatic logic [CNT_W-1:0] sat_cnt(input logic [DIV_NUM_W-1:0] q);
    return (q[DIV_NUM_W-1:CNT_W] != '0) ? {CNT_W{1'b1}} : q[CNT_W-1:0];
  endfunction

  function automatic logic [PM_W-1:0] sat_pm(input logic [DIV_NUM_W-1:0] q);
    return (q[DIV_NUM_W-1:PM_W] != '0) ? {PM_W{1'b1}} : q[PM_W-1:0];
  endfunction

  assign in_ready = (state == S_IDLE);

  always_comb begin
    win_ext   = CMP_W'(cfg_win);
    win_max   = CMP_W'(MAX_WINDOW);
    win_clamp = (win_ext == '0) ? CMP_W'(1) :
                (win_ext > win_max) ? win_max : win_ext;
    win       = win_clamp[FILL_W-1:0];
    head_sum  = SUM_W'(ring_head) + SUM_W'(ring_fill - win) + SUM_W'(1);
    slot_sum  = SUM_W'(ring_head) + SUM_W'(ring_fill);
    slot      = wrap_idx(slot_sum);
  end

  assign sub_in  = {1'b0, smp_new.in_bytes}  - {1'b0, smp_old.in_bytes};
  assign sub_out = {1'b0, smp_new.out_bytes} - {1'b0, smp_old.out_bytes};

  assign div_num   = times_1000(mul_x);
  assign job_go    = job_ok && (div_den != '0);
  assign div_start = (state == S_MUL) && job_go;
  assign job_wr    = ((state == S_MUL) && !job_go) || ((state == S_DIV) && div_stat.done);
  assign job_q     = (state == S_DIV) ? div_quot : '0;

  wtrm_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (div_num),
    .den    (div_den),
    .status (div_stat),
    .quot   (div_quot)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_win <= WIN_RESET;
      max_in  <= '0;
      max_out <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_SAMPLES: cfg_win <= cfg_data[WIN_W-1:0];
        REG_MAX_IN_RATE:    max_in  <= cfg_data[CNT_W-1:0];
        REG_MAX_OUT_RATE:   max_out <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      job       <= J_IN_RATE;
      ring_head <= '0;
      ring_fill <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_OUT) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_RING;
          end
        end
        S_RING: begin
          // drop the oldest samples until fewer than the window remain
          if (ring_fill >= win) begin
            ring_head <= wrap_idx(head_sum);
            ring_fill <= win - FILL_W'(1);
          end
          state <= S_WRITE;
        end
        S_WRITE: begin
          ring_fill <= ring_fill + FILL_W'(1);
          state     <= S_CHECK;
        end
        S_CHECK: begin
          job   <= J_IN_RATE;
          state <= S_PREP;
        end
        S_PREP: state <= S_MUL;
        S_MUL: begin
          state <= job_go ? S_DIV : S_NEXT;
        end
        S_DIV: begin
          if (div_stat.done) begin
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (job == J_TOT_PM) begin
            state <= S_OUT;
          end else begin
            job   <= job_t'(job + 3'd1);
            state <= S_PREP;
          end
        end
        S_OUT: begin
          // hold until the previous result has been taken
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ring store and read of the oldest sample
  always_ff @(posedge clk) begin
    if (state == S_WRITE) begin
      ring_mem[slot] <= smp_new;
      smp_old        <= ring_mem[ring_head];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      smp_new <= in_data;
    end
    if (state == S_CHECK) begin
      span_ok   <= (ring_fill >= FILL_W'(2)) &&
                   (smp_old.device_id == smp_new.device_id) &&
                   (smp_new.time_ms > smp_old.time_ms);
      dt        <= smp_new.time_ms - smp_old.time_ms;
      delta_in  <= sub_in[CNT_W-1:0];
      in_fell   <= sub_in[CNT_W];
      delta_out <= sub_out[CNT_W-1:0];
      out_fell  <= sub_out[CNT_W];
    end
    if (state == S_PREP) begin
      case (job)
        J_IN_RATE: begin
          mul_x   <= {1'b0, delta_in};
          div_den <= {1'b0, dt};
          job_ok  <= span_ok && !in_fell;
        end
        J_OUT_RATE: begin
          mul_x   <= {1'b0, delta_out};
          div_den <= {1'b0, dt};
          job_ok  <= span_ok && !out_fell;
        end
        J_IN_PM: begin
          mul_x   <= {1'b0, in_rate};
          div_den <= {1'b0, max_in};
          job_ok  <= 1'b1;
        end
        J_OUT_PM: begin
          mul_x   <= {1'b0, out_rate};
          div_den <= {1'b0, max_out};
          job_ok  <= 1'b1;
        end
        default: begin
          mul_x   <= {1'b0, in_rate} + {1'b0, out_rate};
          div_den <= {1'b0, max_in} + {1'b0, max_out};
          job_ok  <= 1'b1;
        end
      endcase
    end
    if (job_wr) begin
      case (job)
        J_IN_RATE:  in_rate  <= sat_cnt(job_q);
        J_OUT_RATE: out_rate <= sat_cnt(job_q);
        J_IN_PM:    in_pm    <= sat_pm(job_q);
        J_OUT_PM:   out_pm   <= sat_pm(job_q);
        default:    tot_pm   <= sat_pm(job_q);
      endcase
    end
    if ((state == S_OUT) && (!out_valid || out_ready)) begin
      out_data <= '{in_total:       smp_new.in_bytes,
                    out_total:      smp_new.out_bytes,
                    in_rate:        in_rate,
                    out_rate:       out_rate,
                    in_permille:    in_pm,
                    out_permille:   out_pm,
                    total_permille: tot_pm};
    end
  end

`ifndef SYNTHESIS
  a_div_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_ring_bounds: assert property (@(posedge clk) disable iff (rst)
    (SUM_W'(ring_head) < SUM_W'(MAX_WINDOW)) && (ring_fill <= FILL_W'(MAX_WINDOW)))
    else $error("ring head or fill out of range");

  a_out_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result raised outside the output load");

  a_fill_after_store: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> (ring_fill != '0))
    else $error("ring empty after storing a sample");
`endif

endmodule

// ----- src/wtrm_div.sv -----
// ----------------------------------------------------------------------------
// wtrm_div: bit-serial restoring divider
// One quotient bit per cycle; the dividend shifts out of the top of the work
// register while quotient bits shift in at the bottom.
// ----------------------------------------------------------------------------
module wtrm_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [wtrm_pkg::DIV_NUM_W-1:0]   num,
  input  logic [wtrm_pkg::DIV_DEN_W-1:0]   den,
  output wtrm_pkg::div_status_t            status,
  output logic [wtrm_pkg::DIV_NUM_W-1:0]   quot
);
  import wtrm_pkg::*;

  localparam int STEP_W = $clog2(DIV_NUM_W + 1);

  logic [DIV_NUM_W-1:0] work;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den_r;
  logic [STEP_W-1:0]    steps;
  logic                 busy;
  logic                 done;

  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W+1:0] diff;
  logic                 borrow;

  assign trial  = {rem, work[DIV_NUM_W-1]};
  assign diff   = {1'b0, trial} - {2'b00, den_r};
  assign borrow = diff[DIV_DEN_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= !start && busy && (steps == STEP_W'(1));
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DIV_NUM_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work  <= num;
      den_r <= den;
      rem   <= '0;
    end else if (busy) begin
      // keep the remainder below the divisor: it then fits the narrow register
      rem  <= borrow ? trial[DIV_DEN_W-1:0] : diff[DIV_DEN_W-1:0];
      work <= {work[DIV_NUM_W-2:0], ~borrow};
    end
  end

  assign status = '{busy: busy, done: done};
  assign quot   = work;

endmodule
